FILE: rtl/core/fhs_pkg.sv
package fhs_pkg;

  localparam longint unsigned MAX_IMAGE_BYTES_DEF = 64'd1048576;

  localparam int IMAGE_LEN_W = 21;
  localparam int OFFSET_W    = 20;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] CRC_POLY        = 32'hedb88320;
  localparam logic [31:0] SENTINEL_WORD   = 32'hdeadc0de;
  localparam logic [31:0] CRC_PLACEHOLDER = 32'hffffffff;
  localparam logic [31:0] CRC_INIT        = 32'hffffffff;

  // Header word positions after the sentinel; the word that follows it is one.
  localparam logic [2:0] HDR_IDLE   = 3'd0;
  localparam logic [2:0] HDR_FIRST  = 3'd1;
  localparam logic [2:0] HDR_LENGTH = 3'd3;
  localparam logic [2:0] HDR_CRC    = 3'd4;

  localparam logic [2:0] FULL_WORD = 3'd4;
  localparam logic [1:0] HITS_MAX  = 2'd2;

  localparam logic REG_IMAGE_LENGTH = 1'b0;

  typedef enum logic [2:0] {
    ST_OK              = 3'd0,
    ST_EMPTY           = 3'd1,
    ST_NO_SENTINEL     = 3'd2,
    ST_SEVERAL         = 3'd3,
    ST_LENGTH_MISMATCH = 3'd4
  } fhs_status_t;

  typedef struct packed {
    logic [31:0] image_word;
    logic [2:0]  byte_count;
    logic        last;
  } fhs_item_t;

  typedef struct packed {
    logic [31:0]         crc_value;
    logic [OFFSET_W-1:0] sentinel_offset;
    logic [2:0]          status;
  } fhs_result_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    logic [31:0]         fed_word;
    logic [2:0]          count;
    logic                last;
    fhs_status_t         status;
    logic [OFFSET_W-1:0] offset;
  } fhs_entry_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [31:0] crc_word(input logic [31:0] crc, input logic [31:0] w,
                                           input logic [2:0] count);
    logic [31:0] c1;
    logic [31:0] c2;
    logic [31:0] c3;
    logic [31:0] c4;
    logic [31:0] res;
    c1 = crc_byte(crc, w[7:0]);
    c2 = crc_byte(c1, w[15:8]);
    c3 = crc_byte(c2, w[23:16]);
    c4 = crc_byte(c3, w[31:24]);
    case (count)
      3'd1:    res = c1;
      3'd2:    res = c2;
      3'd3:    res = c3;
      3'd4:    res = c4;
      default: res = crc;
    endcase
    return res;
  endfunction

endpackage

FILE: rtl/core/fhs_front.sv
module fhs_front #(
  parameter longint unsigned MAX_IMAGE_BYTES = fhs_pkg::MAX_IMAGE_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_ready,
  input  fhs_pkg::fhs_item_t                 item,
  input  logic [fhs_pkg::IMAGE_LEN_W-1:0]    image_length,
  input  logic                               queue_full,
  output logic                               push,
  output fhs_pkg::fhs_entry_t                push_entry
);

  localparam int BW = $clog2(MAX_IMAGE_BYTES + 64'd2);
  localparam logic [BW:0] SEEN_LIMIT = (BW + 1)'(MAX_IMAGE_BYTES + 64'd1);

  logic [2:0]                     hdr_pos;
  logic [2:0]                     hdr_pos_next;
  logic [1:0]                     hits;
  logic [1:0]                     hits_next;
  logic [fhs_pkg::OFFSET_W-1:0]   offset;
  logic [fhs_pkg::OFFSET_W-1:0]   offset_next;
  logic [BW-1:0]                  seen;
  logic [BW-1:0]                  seen_next;

  logic [2:0]          cnt;
  logic                is_sentinel;
  logic [31:0]         fed;
  logic [BW:0]         seen_sum;
  logic [63:0]         seen_ext;
  fhs_pkg::fhs_status_t status;
  logic                accept;

  assign item_ready = !queue_full;
  assign accept     = item_valid && item_ready;

  assign cnt = (item.byte_count > fhs_pkg::FULL_WORD) ? fhs_pkg::FULL_WORD : item.byte_count;
  assign is_sentinel = (cnt == fhs_pkg::FULL_WORD) && (item.image_word == fhs_pkg::SENTINEL_WORD);
  assign seen_sum = {1'b0, seen} + (BW + 1)'(cnt);
  assign seen_ext = 64'(seen);

  always_comb begin
    case (hdr_pos)
      fhs_pkg::HDR_LENGTH: fed = 32'(image_length);
      fhs_pkg::HDR_CRC:    fed = fhs_pkg::CRC_PLACEHOLDER;
      default:             fed = item.image_word;
    endcase
  end

  always_comb begin
    hdr_pos_next = hdr_pos;
    hits_next    = hits;
    offset_next  = offset;
    seen_next    = seen;
    if (cnt != 3'd0) begin
      if (is_sentinel) begin
        hits_next    = (hits < fhs_pkg::HITS_MAX) ? hits + 2'd1 : hits;
        offset_next  = seen_ext[fhs_pkg::OFFSET_W-1:0];
        hdr_pos_next = fhs_pkg::HDR_FIRST;
      end else if (hdr_pos != fhs_pkg::HDR_IDLE) begin
        hdr_pos_next = (hdr_pos >= fhs_pkg::HDR_CRC) ? fhs_pkg::HDR_IDLE : hdr_pos + 3'd1;
      end
      seen_next = (seen_sum > SEEN_LIMIT) ? SEEN_LIMIT[BW-1:0] : seen_sum[BW-1:0];
    end
  end

  always_comb begin
    if (seen_next == '0) begin
      status = fhs_pkg::ST_EMPTY;
    end else if (hits_next == 2'd0) begin
      status = fhs_pkg::ST_NO_SENTINEL;
    end else if (hits_next >= fhs_pkg::HITS_MAX) begin
      status = fhs_pkg::ST_SEVERAL;
    end else if (64'(seen_next) > MAX_IMAGE_BYTES || 64'(seen_next) != 64'(image_length)) begin
      status = fhs_pkg::ST_LENGTH_MISMATCH;
    end else begin
      status = fhs_pkg::ST_OK;
    end
  end

  assign push                = accept;
  assign push_entry.fed_word = fed;
  assign push_entry.count    = cnt;
  assign push_entry.last     = item.last;
  assign push_entry.status   = status;
  assign push_entry.offset   = offset_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_pos <= fhs_pkg::HDR_IDLE;
      hits    <= 2'd0;
      offset  <= '0;
      seen    <= '0;
    end else if (accept) begin
      if (item.last) begin
        // start over for the next image
        hdr_pos <= fhs_pkg::HDR_IDLE;
        hits    <= 2'd0;
        offset  <= '0;
        seen    <= '0;
      end else begin
        hdr_pos <= hdr_pos_next;
        hits    <= hits_next;
        offset  <= offset_next;
        seen    <= seen_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_hits_saturate: assert property (@(posedge clk) disable iff (rst)
    hits <= fhs_pkg::HITS_MAX)
    else $error("sentinel hit count past saturation");

  a_hdr_range: assert property (@(posedge clk) disable iff (rst)
    hdr_pos <= fhs_pkg::HDR_CRC)
    else $error("header position out of range");

  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    accept && item.last |=> seen == '0 && hits == 2'd0 && hdr_pos == fhs_pkg::HDR_IDLE)
    else $error("stream state not cleared after last request");
`endif

endmodule

FILE: rtl/core/fhs_queue.sv
module fhs_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  fhs_pkg::fhs_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output fhs_pkg::fhs_entry_t head
);

  fhs_pkg::fhs_entry_t slots [fhs_pkg::QUEUE_DEPTH];

  logic [fhs_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [fhs_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [fhs_pkg::QUEUE_CNT_W-1:0] fill;
  logic [fhs_pkg::QUEUE_CNT_W-1:0] fill_next;

  assign full       = (fill == fhs_pkg::QUEUE_CNT_W'(fhs_pkg::QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head       = slots[rd_ptr];

  always_comb begin
    fill_next = fill;
    case ({push, pop})
      2'b10:   fill_next = fill + 1'b1;
      2'b01:   fill_next = fill - 1'b1;
      default: fill_next = fill;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill_next;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= fhs_pkg::QUEUE_CNT_W'(fhs_pkg::QUEUE_DEPTH))
    else $error("queue fill past depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");
`endif

endmodule

FILE: rtl/core/fhs_back.sv
module fhs_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  fhs_pkg::fhs_entry_t  head,
  output logic                 pop,
  output logic                 result_valid,
  input  logic                 result_ready,
  output fhs_pkg::fhs_result_t result
);

  logic [31:0] crc;
  logic [31:0] crc_next;

  assign crc_next = fhs_pkg::crc_word(crc, head.fed_word, head.count);
  // a last request needs a free result slot; other requests drain freely
  assign pop = head_valid && (!head.last || !result_valid || result_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      crc          <= fhs_pkg::CRC_INIT;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      if (pop) begin
        if (head.last) begin
          crc          <= fhs_pkg::CRC_INIT;
          result_valid <= 1'b1;
        end else begin
          crc <= crc_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      result.crc_value       <= ~crc_next;
      result.sentinel_offset <= head.offset;
      result.status          <= 3'(head.status);
    end
  end

endmodule

FILE: rtl/core/firmware_header_stamp_crc32.sv
// Firmware header stamp CRC-32. Image words stream in one per cycle while
// item_ready is high, first byte in bits 7:0; a partial word is allowed only
// on the last request. The front end counts sentinel words (0xDEADC0DE), tracks
// the four-word header after the latest one and substitutes the length word
// with image_length and the crc word with all ones; a four-entry queue
// decouples it from the back end, which runs a one-word-per-cycle reflected
// CRC-32 (a last word waits for a free output) and holds the result in an
// output register. Sustained rate is one word per clock while the queue is not
// full, limited by the CRC update. image_length sits at byte address 0 of the
// APB port and must be written while no image is in flight.
module firmware_header_stamp_crc32 #(
  parameter longint unsigned MAX_IMAGE_BYTES = fhs_pkg::MAX_IMAGE_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  fhs_pkg::fhs_item_t   item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output fhs_pkg::fhs_result_t result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [fhs_pkg::IMAGE_LEN_W-1:0] image_length;
  logic                            queue_full;
  logic                            push;
  fhs_pkg::fhs_entry_t             push_entry;
  logic                            pop;
  logic                            head_valid;
  fhs_pkg::fhs_entry_t             head;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == fhs_pkg::REG_IMAGE_LENGTH) ? 32'(image_length) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_length <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == fhs_pkg::REG_IMAGE_LENGTH) begin
      image_length <= pwdata[fhs_pkg::IMAGE_LEN_W-1:0];
    end
  end

  fhs_front #(
    .MAX_IMAGE_BYTES(MAX_IMAGE_BYTES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .image_length (image_length),
    .queue_full   (queue_full),
    .push         (push),
    .push_entry   (push_entry)
  );

  fhs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  fhs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
